// File: src/knwr_pkg.sv
// Shared types and constants for the k-nearest-within-radius search block.
// Used by the sorting cells, the distance unit and the top level.
package knwr_pkg;

  localparam int MAX_AGENTS  = 256;
  localparam int MAX_RESULTS = 16;

  localparam int COORD_W   = 16;
  localparam int RADIUS_W  = 16;
  localparam int REQ_W     = 5;
  localparam int IDX_W     = $clog2(MAX_AGENTS);
  localparam int SCAN_W    = $clog2(MAX_AGENTS + 1);
  localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int DIST_W    = 34;
  localparam int RSQ_W     = 2 * RADIUS_W;
  localparam int SQ_W      = 2 * COORD_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              v;
    logic [DIST_W-1:0] d;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic shl;
  } chain_ctrl_t;

endpackage

// File: src/k_nearest_within_radius_top.sv
// Top level of the k-nearest-within-radius search: control, agent store and chain.
// Depends on knwr_pkg, knwr_ram, knwr_dist and knwr_cell.
//
// A write item updates one agent entry. A query item scans agent_count entries
// (agent_count taken as at most 256) through the position store, which has one
// read port and gives one entry a cycle into the distance pipeline and the
// sorted chain of cells, and then delivers its results one at a time as the
// output register frees (one result when no agent qualifies); a query with a zero
// count or an agent_count of zero goes straight to its single empty result. The
// next item is taken once the last result of a query has moved into the output register.
module k_nearest_within_radius_top
  import knwr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // agent_slot, agent_x, agent_y, agent_active, query_x, query_y, query_radius,
  // request_count
  input  logic [95:0] s_axis_tdata,
  // opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // found, agent_index, distance_sq
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  logic [IDX_W-1:0]   in_slot;
  logic [COORD_W-1:0] in_ax, in_ay, in_qx, in_qy;
  logic               in_act;
  logic [RADIUS_W-1:0] in_r;
  logic [REQ_W-1:0]   in_req;

  assign in_slot = s_axis_tdata[7:0];
  assign in_ax   = s_axis_tdata[23:8];
  assign in_ay   = s_axis_tdata[39:24];
  assign in_act  = s_axis_tdata[40];
  assign in_qx   = s_axis_tdata[56:41];
  assign in_qy   = s_axis_tdata[72:57];
  assign in_r    = s_axis_tdata[88:73];
  assign in_req  = s_axis_tdata[93:89];

  state_e               state_q, state_d;
  logic [8:0]           agent_count_q;
  logic [SCAN_W-1:0]    scan_q, scan_d, k_q, k_d;
  logic [RES_CNT_W-1:0] n_q, n_d, cnt_q, cnt_d, rem_q, rem_d;
  logic [COORD_W-1:0]   qx_q, qx_d, qy_q, qy_d;
  logic [RSQ_W-1:0]     rsq_q, rsq_d;
  logic                 v1_q, v1_d, act1_q, act1_d;
  logic [IDX_W-1:0]     idx1_q, idx1_d;
  logic                 out_v_q, out_v_d, out_found_q, out_found_d, out_last_q, out_last_d;
  logic [IDX_W-1:0]     out_idx_q, out_idx_d;
  logic [DIST_W-1:0]    out_dist_q, out_dist_d;
  logic                 act_q [MAX_AGENTS];

  logic                 in_acc, is_query, is_write, out_free;
  logic [SCAN_W-1:0]    scan_sat;
  logic [RES_CNT_W-1:0] n_sat;
  logic [2*COORD_W-1:0] ram_rdata;
  entry_t               cand;
  logic                 dist_busy;
  chain_ctrl_t          chain_ctrl;
  entry_t               ent  [MAX_RESULTS];
  logic                 take [MAX_RESULTS];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign is_query = in_acc & (s_axis_tuser == OP_QUERY);
  assign is_write = in_acc & (s_axis_tuser == OP_WRITE);
  assign out_free = ~out_v_q | m_axis_tready;

  assign scan_sat = (agent_count_q > 9'(MAX_AGENTS)) ? SCAN_W'(MAX_AGENTS)
                                                      : SCAN_W'(agent_count_q);
  assign n_sat    = (in_req > REQ_W'(MAX_RESULTS)) ? RES_CNT_W'(MAX_RESULTS)
                                                   : RES_CNT_W'(in_req);

  knwr_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_AGENTS)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (is_write),
    .waddr_i (in_slot),
    .wdata_i ({in_ay, in_ax}),
    .raddr_i (k_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  knwr_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_v_i   (v1_q & act1_q),
    .in_idx_i (idx1_q),
    .ax_i     (ram_rdata[COORD_W-1:0]),
    .ay_i     (ram_rdata[2*COORD_W-1:COORD_W]),
    .qx_i     (qx_q),
    .qy_i     (qy_q),
    .rsq_i    (rsq_q),
    .cand_o   (cand),
    .busy_o   (dist_busy)
  );

  assign chain_ctrl.clr = is_query;
  assign chain_ctrl.shl = (state_q == ST_EMIT) & out_free & (rem_q != '0);

  for (genvar i = 0; i < MAX_RESULTS; i++) begin : g_cell
    entry_t prev_ent, next_ent;
    logic   prev_take;
    if (i == 0) begin : g_head
      assign prev_ent  = '0;
      assign prev_take = 1'b0;
    end else begin : g_body
      assign prev_ent  = ent[i-1];
      assign prev_take = take[i-1];
    end
    if (i == MAX_RESULTS - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ent[i+1];
    end
    knwr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (chain_ctrl),
      .ins_i       (cand),
      .prev_i      (prev_ent),
      .prev_take_i (prev_take),
      .next_i      (next_ent),
      .ent_o       (ent[i]),
      .take_o      (take[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    k_d         = k_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    rsq_d       = rsq_q;
    v1_d        = 1'b0;
    act1_d      = act1_q;
    idx1_d      = idx1_q;
    out_v_d     = out_v_q & ~m_axis_tready;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    out_dist_d  = out_dist_q;
    out_last_d  = out_last_q;

    if (cand.v && (cnt_q < RES_CNT_W'(MAX_RESULTS))) begin
      cnt_d = cnt_q + RES_CNT_W'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (is_query) begin
          qx_d   = in_qx;
          qy_d   = in_qy;
          rsq_d  = RSQ_W'(in_r) * RSQ_W'(in_r);
          n_d    = n_sat;
          scan_d = scan_sat;
          cnt_d  = '0;
          k_d    = '0;
          rem_d  = '0;
          if ((n_sat == '0) || (scan_sat == '0)) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        v1_d   = 1'b1;
        idx1_d = k_q[IDX_W-1:0];
        act1_d = act_q[k_q[IDX_W-1:0]];
        k_d    = k_q + SCAN_W'(1);
        if (k_d == scan_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !dist_busy) begin
          rem_d   = (cnt_q < n_q) ? cnt_q : n_q;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_v_d = 1'b1;
          if (rem_q == '0) begin
            out_found_d = 1'b0;
            out_idx_d   = '0;
            out_dist_d  = '0;
            out_last_d  = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            out_found_d = 1'b1;
            out_idx_d   = ent[0].idx;
            out_dist_d  = ent[0].d;
            out_last_d  = (rem_q == RES_CNT_W'(1));
            rem_d       = rem_q - RES_CNT_W'(1);
            if (rem_q == RES_CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      agent_count_q <= '0;
      scan_q        <= '0;
      k_q           <= '0;
      n_q           <= '0;
      cnt_q         <= '0;
      rem_q         <= '0;
      v1_q          <= 1'b0;
      out_v_q       <= 1'b0;
      out_found_q   <= 1'b0;
      out_idx_q     <= '0;
      out_dist_q    <= '0;
      out_last_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        agent_count_q <= cfg_wdata_i;
      end
      scan_q      <= scan_d;
      k_q         <= k_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      v1_q        <= v1_d;
      out_v_q     <= out_v_d;
      out_found_q <= out_found_d;
      out_idx_q   <= out_idx_d;
      out_dist_q  <= out_dist_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    rsq_q  <= rsq_d;
    act1_q <= act1_d;
    idx1_q <= idx1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_AGENTS; i++) begin
        act_q[i] <= 1'b0;
      end
    end else if (is_write) begin
      act_q[in_slot] <= in_act;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b0, out_dist_q, out_idx_q, out_found_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// File: src/knwr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module knwr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/knwr_cell.sv
// One cell of the sorted insertion chain: holds one candidate by distance.
// Depends on knwr_pkg.
module knwr_cell
  import knwr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chain_ctrl_t ctrl_i,
  input  entry_t      ins_i,
  input  entry_t      prev_i,
  input  logic        prev_take_i,
  input  entry_t      next_i,
  output entry_t      ent_o,
  output logic        take_o
);

  logic              v_q, v_d;
  logic [DIST_W-1:0] d_q, d_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  // A later candidate with an equal distance goes behind the held one.
  assign take_o = ins_i.v & (~v_q | (ins_i.d < d_q));

  always_comb begin
    v_d   = v_q;
    d_d   = d_q;
    idx_d = idx_q;
    priority if (ctrl_i.clr) begin
      v_d = 1'b0;
    end else if (ctrl_i.shl) begin
      v_d   = next_i.v;
      d_d   = next_i.d;
      idx_d = next_i.idx;
    end else if (take_o) begin
      if (prev_take_i) begin
        v_d   = prev_i.v;
        d_d   = prev_i.d;
        idx_d = prev_i.idx;
      end else begin
        v_d   = 1'b1;
        d_d   = ins_i.d;
        idx_d = ins_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    idx_q <= idx_d;
  end

  assign ent_o = '{v: v_q, d: d_q, idx: idx_q};

endmodule

// File: src/knwr_dist.sv
// Three-stage squared-distance and radius test for one stored agent a cycle.
// Depends on knwr_pkg.
module knwr_dist
  import knwr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_v_i,
  input  logic [IDX_W-1:0]   in_idx_i,
  input  logic [COORD_W-1:0] ax_i,
  input  logic [COORD_W-1:0] ay_i,
  input  logic [COORD_W-1:0] qx_i,
  input  logic [COORD_W-1:0] qy_i,
  input  logic [RSQ_W-1:0]   rsq_i,
  output entry_t             cand_o,
  output logic               busy_o
);

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]      ux_d, uy_d;
  logic [SQ_W:0]           sum;

  logic                    v2_q, v3_q, v4_q;
  logic [IDX_W-1:0]        idx2_q, idx3_q, idx4_q;
  logic [COORD_W-1:0]      ux_q, uy_q;
  logic [SQ_W-1:0]         sqx_q, sqy_q;
  logic [DIST_W-1:0]       d4_q;
  logic                    hit;

  assign dx   = $signed({qx_i[COORD_W-1], qx_i}) - $signed({ax_i[COORD_W-1], ax_i});
  assign dy   = $signed({qy_i[COORD_W-1], qy_i}) - $signed({ay_i[COORD_W-1], ay_i});
  assign ux_d = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign uy_d = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  assign sum  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign hit  = (sum <= {1'b0, rsq_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= in_v_i;
      v3_q <= v2_q;
      v4_q <= v3_q & hit;
    end
  end

  always_ff @(posedge clk_i) begin
    idx2_q <= in_idx_i;
    ux_q   <= ux_d;
    uy_q   <= uy_d;
    idx3_q <= idx2_q;
    sqx_q  <= SQ_W'(ux_q) * SQ_W'(ux_q);
    sqy_q  <= SQ_W'(uy_q) * SQ_W'(uy_q);
    idx4_q <= idx3_q;
    d4_q   <= DIST_W'(sum);
  end

  assign cand_o = '{v: v4_q, d: d4_q, idx: idx4_q};
  assign busy_o = v2_q | v3_q | v4_q;

endmodule
